// ===== rtl/sses_pkg.sv =====
// Shared types and constants of the state-space Euler step unit.
// No dependencies; compile first.
package sses_pkg;

    // Fixed item widths
    localparam int DATA_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_W     = 16;
    localparam int STEP_W     = 16;
    localparam int MAX_STATES = 4;

    // Fixed-point formats
    localparam int COEFF_FRAC = 14;
    localparam int STEP_FRAC  = 16;

    // Extra accumulator bits for up to MAX_STATES + 1 terms
    localparam int ACC_GUARD  = 3;

    // Lane selector: codes 0..MAX_STATES
    localparam int SEL_W      = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAINS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd5;

    localparam logic [STEP_W-1:0]        STEP_RESET  = 16'd655;
    localparam logic signed [DATA_W-1:0] STATE0_INIT = 32'sd6554;
    localparam logic signed [DATA_W-1:0] Q_MAX       = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN       = 32'sh8000_0000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_SCALE,
        S_UPDATE,
        S_OUT
    } t_seq_state;

    // Per-cycle command to every lane
    typedef struct packed {
        logic             clear;
        logic             mac_en;
        logic [SEL_W-1:0] sel;
        logic             round_en;
        logic             scale_en;
        logic             commit;
    } t_lane_ctl;

endpackage

// ===== rtl/sses_if.sv =====
// Channel interfaces of the state-space Euler step unit: drive items,
// result items and configuration writes. Depends on sses_pkg.

interface sses_in_if;
    import sses_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_zero;
    logic signed [DATA_W-1:0] drive_one;
    logic signed [DATA_W-1:0] drive_two;
    logic signed [DATA_W-1:0] drive_three;
    modport source (output valid, drive_zero, drive_one, drive_two, drive_three,
                    input ready);
    modport sink   (input valid, drive_zero, drive_one, drive_two, drive_three,
                    output ready);
endinterface

interface sses_out_if;
    import sses_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] next_zero;
    logic signed [DATA_W-1:0] next_one;
    logic signed [DATA_W-1:0] next_two;
    logic signed [DATA_W-1:0] next_three;
    logic                     saturated;
    modport source (output valid, next_zero, next_one, next_two, next_three,
                    saturated, input ready);
    modport sink   (input valid, next_zero, next_one, next_two, next_three,
                    saturated, output ready);
endinterface

interface sses_cfg_if;
    import sses_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sses_lane.sv =====
// One state row: shared multiply-accumulate over the row, rounding, time-step
// scaling, clamped update of this row's state. Depends on sses_pkg.
module sses_lane #(
    parameter int SC   = 4,
    parameter int CW   = 16,
    parameter int LANE = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sses_pkg::CFG_DATA_W-1:0]   i_row,
    input  logic signed [CW-1:0]              i_gain,
    input  logic signed [sses_pkg::DATA_W-1:0] i_drive,
    input  logic [sses_pkg::STEP_W-1:0]       i_step,
    input  logic signed [sses_pkg::DATA_W-1:0] i_states [SC],
    input  sses_pkg::t_lane_ctl               i_ctl,
    output logic signed [sses_pkg::DATA_W-1:0] o_state,
    output logic                              o_sat
);
    import sses_pkg::*;

    localparam int PROD_W = CW + DATA_W;
    localparam int ACC_W  = PROD_W + ACC_GUARD;
    localparam int D_W    = ACC_W + 1 - COEFF_FRAC;
    localparam int P_W    = D_W + STEP_W + 1;
    localparam int INC_W  = P_W + 1 - STEP_FRAC;
    localparam int NV_W   = INC_W + 1;

    localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W + 1)'(1) <<< (COEFF_FRAC - 1);
    localparam logic signed [P_W:0]   TP_HALF  = (P_W + 1)'(1) <<< (STEP_FRAC - 1);
    localparam logic signed [DATA_W-1:0] INIT  = (LANE == 0) ? STATE0_INIT : '0;

    logic signed [CW-1:0]     w_a;
    logic signed [DATA_W-1:0] w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_acc_en;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W:0]    w_acc_r;
    logic signed [D_W-1:0]    r_d16;
    logic signed [P_W-1:0]    w_tp;
    logic signed [P_W:0]      w_tp_r;
    logic signed [INC_W-1:0]  r_inc;
    logic signed [NV_W-1:0]   w_nv;
    logic signed [DATA_W-1:0] r_state;
    logic                     r_sat;

    // Pick coefficient and operand: row terms first, drive term last
    always_comb begin
        w_a = i_gain;
        w_b = i_drive;
        for (int j = 0; j < SC; j++) begin
            if (i_ctl.sel == SEL_W'(j)) begin
                w_a = i_row[LANE_W*j +: CW];
                w_b = i_states[j];
            end
        end
    end

    assign w_mul = PROD_W'(w_a) * PROD_W'(w_b);

    // Register the product, accumulate it in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_ctl.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_en) begin
            r_prod <= w_mul;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round the row sum to Q16.16, half up
    assign w_acc_r = (ACC_W + 1)'(r_acc) + ACC_HALF;

    // Scale by the time step, round half up
    assign w_tp   = P_W'(r_d16) * P_W'($signed({1'b0, i_step}));
    assign w_tp_r = (P_W + 1)'(w_tp) + TP_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.round_en) begin
            r_d16 <= w_acc_r[ACC_W:COEFF_FRAC];
        end
        if (i_ctl.scale_en) begin
            r_inc <= w_tp_r[P_W:STEP_FRAC];
        end
    end

    // Add the increment and clamp to the Q16.16 range
    assign w_nv = NV_W'(r_state) + NV_W'(r_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= INIT;
            r_sat   <= 1'b0;
        end else if (i_ctl.commit) begin
            if (w_nv > NV_W'(Q_MAX)) begin
                r_state <= Q_MAX;
                r_sat   <= 1'b1;
            end else if (w_nv < NV_W'(Q_MIN)) begin
                r_state <= Q_MIN;
                r_sat   <= 1'b1;
            end else begin
                r_state <= w_nv[DATA_W-1:0];
                r_sat   <= 1'b0;
            end
        end
    end

    assign o_state = r_state;
    assign o_sat   = r_sat;

endmodule

// ===== rtl/sses_ctrl.sv =====
// Sequencer of the lanes: accepts a drive item, steps the multiply-accumulate
// over the row, then rounds, scales, commits and hands off. Depends on sses_pkg.
module sses_ctrl #(
    parameter int SC = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_free,
    output logic                o_in_ready,
    output logic                o_load,
    output sses_pkg::t_lane_ctl o_ctl
);
    import sses_pkg::*;

    localparam int CNT_W = $clog2(SC + 1);

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MAC;
            S_MAC:    if (r_cnt == CNT_W'(SC)) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_ROUND;
            S_ROUND:  n_state = S_SCALE;
            S_SCALE:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT:    if (i_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MAC) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Outputs
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        o_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.clear = w_accept;
            end
            S_MAC: begin
                o_ctl.mac_en = 1'b1;
                o_ctl.sel    = SEL_W'(r_cnt);
            end
            S_DRAIN:  ;
            S_ROUND:  o_ctl.round_en = 1'b1;
            S_SCALE:  o_ctl.scale_en = 1'b1;
            S_UPDATE: o_ctl.commit   = 1'b1;
            S_OUT:    o_load         = i_free;
            default:  ;
        endcase
    end

endmodule

// ===== rtl/sses_merge.sv =====
// Merge stage: gathers the lane states and clamp flags into one result item
// and holds it until taken. Depends on sses_pkg and sses_if.
module sses_merge #(
    parameter int SC = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [sses_pkg::DATA_W-1:0] i_states [SC],
    input  logic [SC-1:0]                      i_sats,
    input  logic                               i_load,
    output logic                               o_free,
    sses_out_if.source                         o_res
);
    import sses_pkg::*;

    logic signed [DATA_W-1:0] w_full [MAX_STATES];
    logic signed [DATA_W-1:0] r_next [MAX_STATES];
    logic                     r_sat;
    logic                     r_valid;

    // Rows past the configured count read as zero
    for (genvar r = 0; r < MAX_STATES; r++) begin : g_full
        if (r < SC) begin : g_used
            assign w_full[r] = i_states[r];
        end else begin : g_unused
            assign w_full[r] = '0;
        end
    end

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the item until the sink takes it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_next <= w_full;
            r_sat  <= |i_sats;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.next_zero  = r_next[0];
    assign o_res.next_one   = r_next[1];
    assign o_res.next_two   = r_next[2];
    assign o_res.next_three = r_next[3];
    assign o_res.saturated  = r_sat;

endmodule

// ===== rtl/state_space_euler_step_unit.sv =====
// Top level of the forward-Euler state-space plant step: configuration
// registers, drive capture, lanes, sequencer, merge. Depends on sses_pkg,
// sses_if, sses_lane, sses_ctrl, sses_merge.
//
//  channel  | modport | moves
//  ---------+---------+---------------------------------------------
//  i_in     | sink    | one tick item: four Q16.16 drive values
//  o_res    | source  | one result item: four new states, clamp flag
//  i_cfg    | sink    | register write: index 0..5, 64-bit data
//
// From acceptance to the next acceptance an item runs SC + 1 multiply-accumulate
// steps on each lane's single multiplier, then drain, round, scale, commit and
// hand-off, which waits until the output register is free.
// All lanes run the same steps in parallel, one row each.
// Reset is synchronous, active low: state 0 becomes 0.1, others zero,
// coefficients zero, time step 655. Configuration writes are always taken.
// A stalled result waits in the output register; a new item may be accepted
// meanwhile and waits for the register before it is handed off.
module state_space_euler_step_unit #(
    parameter int STATE_COUNT = 4,
    parameter int COEFF_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sses_in_if.sink    i_in,
    sses_out_if.source o_res,
    sses_cfg_if.sink   i_cfg
);
    import sses_pkg::*;

    localparam int SC = STATE_COUNT;
    localparam int CW = COEFF_WIDTH;

    logic [CFG_DATA_W-1:0]    r_rows [SC];
    logic [CFG_DATA_W-1:0]    r_gains;
    logic [STEP_W-1:0]        r_step;
    logic signed [DATA_W-1:0] w_in_drive [MAX_STATES];
    logic signed [DATA_W-1:0] r_drive [SC];
    logic signed [DATA_W-1:0] w_states [SC];
    logic [SC-1:0]            w_sats;
    t_lane_ctl                w_ctl;
    logic                     w_free;
    logic                     w_load;
    logic                     w_in_acc;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SC; r++) begin
                r_rows[r] <= '0;
            end
            r_gains <= '0;
            r_step  <= STEP_RESET;
        end else if (i_cfg.valid) begin
            for (int r = 0; r < SC; r++) begin
                if (i_cfg.index == CFG_ROW_ZERO + CFG_IDX_W'(r)) begin
                    r_rows[r] <= i_cfg.data;
                end
            end
            if (i_cfg.index == CFG_DRIVE_GAINS) begin
                r_gains <= i_cfg.data;
            end
            if (i_cfg.index == CFG_TIME_STEP) begin
                r_step <= i_cfg.data[STEP_W-1:0];
            end
        end
    end

    // Capture the drive values of an accepted item
    assign w_in_drive[0] = i_in.drive_zero;
    assign w_in_drive[1] = i_in.drive_one;
    assign w_in_drive[2] = i_in.drive_two;
    assign w_in_drive[3] = i_in.drive_three;

    assign w_in_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int r = 0; r < SC; r++) begin
                r_drive[r] <= w_in_drive[r];
            end
        end
    end

    sses_ctrl #(
        .SC (SC)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_free     (w_free),
        .o_in_ready (i_in.ready),
        .o_load     (w_load),
        .o_ctl      (w_ctl)
    );

    for (genvar r = 0; r < SC; r++) begin : g_lane
        sses_lane #(
            .SC   (SC),
            .CW   (CW),
            .LANE (r)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_row    (r_rows[r]),
            .i_gain   (r_gains[LANE_W*r +: CW]),
            .i_drive  (r_drive[r]),
            .i_step   (r_step),
            .i_states (w_states),
            .i_ctl    (w_ctl),
            .o_state  (w_states[r]),
            .o_sat    (w_sats[r])
        );
    end

    sses_merge #(
        .SC (SC)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_states (w_states),
        .i_sats   (w_sats),
        .i_load   (w_load),
        .o_free   (w_free),
        .o_res    (o_res)
    );

    // Busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    // Hand-off only into a free output register
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_free)
        else $error("result loaded over a pending item");

    // A clamp flag comes with some state at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.saturated) |->
            (o_res.next_zero == Q_MAX || o_res.next_zero == Q_MIN ||
             o_res.next_one == Q_MAX || o_res.next_one == Q_MIN ||
             o_res.next_two == Q_MAX || o_res.next_two == Q_MIN ||
             o_res.next_three == Q_MAX || o_res.next_three == Q_MIN))
        else $error("clamp flag without a clamped state");

    // Out of reset: ready for an item, no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in.ready && !o_res.valid))
        else $error("not idle after reset");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for state_space_euler_step_unit: directed rows, then random phases.
// Holds its own plant predictor. Needs sses_pkg, sses_if and the unit's RTL.

module tb;
    import sses_pkg::*;

    localparam int N_STATE         = 4;
    localparam int COEFF_W         = 16;
    localparam int TICK_CYCLES     = N_STATE + 7;
    localparam int IDLE_PCT        = 23;
    localparam int HOLD_CYCLES     = 300;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ROW_IDX_W       = $clog2(MAX_STATES);

    // Indexes past the time step are unmapped and must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_TIME_STEP + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_TIME_STEP + 3'd2;

    typedef logic [MAX_STATES-1:0][DATA_W-1:0] t_quad;

    typedef struct packed {
        t_quad next;
        logic  sat;
    } t_result;

    typedef struct packed {
        logic    typed;
        t_result want;
    } t_pin;

    typedef enum logic [0:0] {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        t_quad                 drive;
        logic                  typed;
        t_result               want;
    } t_stim_row;

    typedef enum logic [1:0] {
        MIX_WILD,
        MIX_SMALL,
        MIX_RAIL,
        MIX_DECAY
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    sses_in_if  tick_ch ();
    sses_out_if res_ch ();
    sses_cfg_if reg_ch ();

    state_space_euler_step_unit #(
        .STATE_COUNT (N_STATE),
        .COEFF_WIDTH (COEFF_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_res   (res_ch),
        .i_cfg   (reg_ch)
    );

    // Predictor copy of registers and plant state
    logic [CFG_DATA_W-1:0]    row_words [MAX_STATES];
    logic [CFG_DATA_W-1:0]    gain_word;
    logic [STEP_W-1:0]        step_word;
    logic signed [DATA_W-1:0] plant_q [MAX_STATES];

    t_result     pending_states [$];
    t_pin        pinned_states [$];
    t_stim_row   stim_rows [$];
    string       lane_name [MAX_STATES] = '{"next_zero", "next_one", "next_two", "next_three"};
    t_mix        phase_mix [N_PHASES] = '{MIX_DECAY, MIX_SMALL, MIX_DECAY, MIX_WILD,
                                          MIX_RAIL, MIX_SMALL};

    int          err_cnt;
    int unsigned cycle_cnt;
    int          hold_left;
    logic        hold_req;
    logic        calm;
    t_result     res_got;
    t_result     res_pred;
    t_pin        pin;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Sign-extend one coefficient lane to a full-width integer
    function automatic longint coeff_lane(logic [CFG_DATA_W-1:0] word, int lane);
        longint v;
        v = longint'({48'b0, word[LANE_W*lane +: LANE_W]});
        v = v <<< (64 - COEFF_W);
        return v >>> (64 - COEFF_W);
    endfunction

    // Advance the predicted plant by one tick and return the new states
    function automatic t_result step_plant(t_quad drive);
        t_result                  res;
        longint                   acc;
        longint                   d16;
        longint                   inc;
        longint                   nv;
        logic signed [DATA_W-1:0] upd [MAX_STATES];
        int                       r;
        int                       j;
        res = '0;
        for (r = 0; r < MAX_STATES; r++) begin
            upd[r] = '0;
            if (r < N_STATE) begin
                acc = 0;
                for (j = 0; j < N_STATE; j++)
                    acc += coeff_lane(row_words[r], j) * longint'(plant_q[j]);
                acc += coeff_lane(gain_word, r) * longint'($signed(drive[r]));
                d16 = (acc + (longint'(1) <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
                inc = (d16 * longint'({48'b0, step_word}) + (longint'(1) <<< (STEP_FRAC - 1)))
                      >>> STEP_FRAC;
                nv = longint'(plant_q[r]) + inc;
                if (nv > longint'(Q_MAX)) begin
                    nv = longint'(Q_MAX);
                    res.sat = 1'b1;
                end else if (nv < longint'(Q_MIN)) begin
                    nv = longint'(Q_MIN);
                    res.sat = 1'b1;
                end
                upd[r] = DATA_W'(nv);
            end
        end
        // All rows use the old states, so commit only after every row is done
        for (r = 0; r < MAX_STATES; r++) begin
            plant_q[r] = upd[r];
            res.next[r] = upd[r];
        end
        return res;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
        if (index < CFG_DRIVE_GAINS)
            row_words[ROW_IDX_W'(index - CFG_ROW_ZERO)] = data;
        else if (index == CFG_DRIVE_GAINS)
            gain_word = data;
        else if (index == CFG_TIME_STEP)
            step_word = data[STEP_W-1:0];
    endfunction

    function automatic t_quad quad(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                   logic [DATA_W-1:0] c, logic [DATA_W-1:0] d);
        return {d, c, b, a};
    endfunction

    function automatic t_result mk_result(t_quad q, logic s);
        t_result res;
        res.next = q;
        res.sat  = s;
        return res;
    endfunction

    function automatic void push_tick(t_quad drive, logic typed, t_result want);
        t_stim_row row;
        row = '0;
        row.kind  = ROW_TICK;
        row.drive = drive;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void push_write(logic [CFG_IDX_W-1:0] index,
                                       logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        stim_rows.push_back(row);
    endfunction

    // Mostly small drives so states stay off the rails, plus full-range and extremes
    function automatic logic [DATA_W-1:0] rand_drive();
        case ($urandom_range(19))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4, 5, 6, 7, 8: return $urandom;
            default: return DATA_W'($urandom_range(2097152)) - 32'd1048576;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coeff_word(t_mix mix, int diag);
        logic [CFG_DATA_W-1:0] w;
        int                    k;
        w = '0;
        for (k = 0; k < MAX_STATES; k++) begin
            case (mix)
                MIX_WILD:  w[LANE_W*k +: LANE_W] = LANE_W'($urandom);
                MIX_SMALL: w[LANE_W*k +: LANE_W] = LANE_W'($urandom_range(2047)) - 16'd1024;
                MIX_RAIL: begin
                    case ($urandom_range(3))
                        0:       w[LANE_W*k +: LANE_W] = 16'h7fff;
                        1:       w[LANE_W*k +: LANE_W] = 16'h8000;
                        2:       w[LANE_W*k +: LANE_W] = 16'h0000;
                        default: w[LANE_W*k +: LANE_W] = 16'hffff;
                    endcase
                end
                default: begin
                    if (k == diag)
                        w[LANE_W*k +: LANE_W] = -LANE_W'($urandom_range(16384, 256));
                    else
                        w[LANE_W*k +: LANE_W] = LANE_W'($urandom_range(511)) - 16'd256;
                end
            endcase
        end
        return w;
    endfunction

    // Offer one tick item and hold it until the unit takes it
    task automatic offer_tick(t_quad drive, logic typed, t_result want);
        t_pin p;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        p.typed = typed;
        p.want  = want;
        pinned_states.push_back(p);
        tick_ch.valid       <= 1'b1;
        tick_ch.drive_zero  <= drive[0];
        tick_ch.drive_one   <= drive[1];
        tick_ch.drive_two   <= drive[2];
        tick_ch.drive_three <= drive[3];
        @(posedge i_clk);
        while (!tick_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= index;
        reg_ch.data  <= data;
        @(posedge i_clk);
        while (!reg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected state item has come back
    task automatic wait_states_out();
        tick_ch.valid <= 1'b0;
        while (pending_states.size() != 0)
            @(negedge i_clk);
    endtask

    // Result side: random back-pressure, calm stretch, and one long hold-off
    initial begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Track register writes and ticks, check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                res_got.next[0] = res_ch.next_zero;
                res_got.next[1] = res_ch.next_one;
                res_got.next[2] = res_ch.next_two;
                res_got.next[3] = res_ch.next_three;
                res_got.sat     = res_ch.saturated;
                if (pending_states.size() == 0) begin
                    $error("result item with no tick pending");
                    err_cnt++;
                end else begin
                    res_pred = pending_states.pop_front();
                    for (int r = 0; r < MAX_STATES; r++) begin
                        if (res_got.next[r] !== res_pred.next[r]) begin
                            $error("%s: expected %0d, got %0d", lane_name[r],
                                   $signed(res_pred.next[r]), $signed(res_got.next[r]));
                            err_cnt++;
                        end
                    end
                    if (res_got.sat !== res_pred.sat) begin
                        $error("saturated: expected %0d, got %0d", res_pred.sat, res_got.sat);
                        err_cnt++;
                    end
                end
            end
            if (reg_ch.valid && reg_ch.ready)
                apply_write(reg_ch.index, reg_ch.data);
            if (tick_ch.valid && tick_ch.ready) begin
                res_pred = step_plant(quad(tick_ch.drive_zero, tick_ch.drive_one,
                                           tick_ch.drive_two, tick_ch.drive_three));
                pin = (pinned_states.size() != 0) ? pinned_states.pop_front() : '0;
                pending_states.push_back(pin.typed ? pin.want : res_pred);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_stim_row             row;
        logic [CFG_DATA_W-1:0] step_data;
        int                    ph;
        int                    n;
        int                    r;

        err_cnt   = 0;
        cycle_cnt = 0;
        hold_req  = 1'b0;
        calm      = 1'b0;
        i_rst_n   = 1'b0;

        tick_ch.valid       = 1'b0;
        tick_ch.drive_zero  = '0;
        tick_ch.drive_one   = '0;
        tick_ch.drive_two   = '0;
        tick_ch.drive_three = '0;
        reg_ch.valid        = 1'b0;
        reg_ch.index        = CFG_ROW_ZERO;
        reg_ch.data         = '0;

        for (r = 0; r < MAX_STATES; r++) begin
            row_words[r] = '0;
            plant_q[r]   = '0;
        end
        gain_word  = '0;
        step_word  = STEP_RESET;
        plant_q[0] = STATE0_INIT;

        // Directed rows
        // Reset values: zero gains and coefficients hold the states
        push_tick(quad(Q_MAX, Q_MIN, '0, '1), 1'b1,
                  mk_result(quad(STATE0_INIT, '0, '0, '0), 1'b0));
        // Unmapped indexes must change nothing
        push_write(CFG_SPARE_A, '1);
        push_write(CFG_SPARE_B, {4{16'h4000}});
        push_tick(quad(32'd1, '1, Q_MAX, Q_MIN), 1'b1,
                  mk_result(quad(STATE0_INIT, '0, '0, '0), 1'b0));
        // Largest gain and step: drive extremes clamp every state
        push_write(CFG_DRIVE_GAINS, {4{16'h7fff}});
        push_write(CFG_TIME_STEP, '1);
        push_tick(quad(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
                  mk_result(quad(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1));
        push_tick(quad(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0);
        push_tick(quad(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
                  mk_result(quad(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1));
        // Zero time step freezes the plant whatever the coefficients
        push_write(CFG_TIME_STEP, 64'hffff_ffff_ffff_0000);
        for (r = 0; r < MAX_STATES; r++)
            push_write(CFG_IDX_W'(CFG_ROW_ZERO + r), {4{16'h8000}});
        push_write(CFG_DRIVE_GAINS, {4{16'h8000}});
        push_tick(quad(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
                  mk_result(quad(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0));
        // Most negative coefficients with the smallest step
        push_write(CFG_TIME_STEP, 64'd1);
        push_tick(quad('0, '0, '0, '0), 1'b0, '0);
        push_tick(quad(Q_MAX, Q_MIN, Q_MAX, Q_MIN), 1'b0, '0);
        push_tick(quad($urandom, $urandom, $urandom, $urandom), 1'b0, '0);
        // Most positive coefficients, gains off, full step
        for (r = 0; r < MAX_STATES; r++)
            push_write(CFG_IDX_W'(CFG_ROW_ZERO + r), {4{16'h7fff}});
        push_write(CFG_DRIVE_GAINS, '0);
        push_write(CFG_TIME_STEP, 64'h0000_0000_0000_ffff);
        push_tick(quad('1, 32'd1, '0, Q_MIN), 1'b0, '0);
        push_tick(quad(Q_MAX, '0, '1, 32'd1), 1'b0, '0);
        // Decaying diagonal, unit gains, default step
        for (r = 0; r < MAX_STATES; r++)
            push_write(CFG_IDX_W'(CFG_ROW_ZERO + r), 64'(16'hc000) << (LANE_W * r));
        push_write(CFG_DRIVE_GAINS, {4{16'h4000}});
        push_write(CFG_TIME_STEP, 64'(STEP_RESET));
        push_tick(quad(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'hffff_8000), 1'b0, '0);
        push_tick(quad(32'h0000_0001, '1, 32'h0000_7fff, 32'h0001_8000), 1'b0, '0);
        for (r = 0; r < 4; r++)
            push_tick(quad(rand_drive(), rand_drive(), rand_drive(), rand_drive()), 1'b0, '0);

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed rows
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_WRITE) begin
                wait_states_out();
                write_reg(row.index, row.data);
            end else begin
                offer_tick(row.drive, row.typed, row.want);
            end
        end

        // Random phases, each with its own register setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_states_out();
            calm = 1'b0;
            for (r = 0; r < MAX_STATES; r++)
                write_reg(CFG_IDX_W'(CFG_ROW_ZERO + r), rand_coeff_word(phase_mix[ph], r));
            write_reg(CFG_DRIVE_GAINS,
                      rand_coeff_word(phase_mix[ph] == MIX_DECAY ? MIX_SMALL : phase_mix[ph],
                                      -1));
            step_data = {$urandom, $urandom};
            case (ph)
                0:       step_data[STEP_W-1:0] = STEP_RESET;
                2:       step_data[STEP_W-1:0] = '1;
                4:       step_data[STEP_W-1:0] = 16'd1;
                default: step_data[STEP_W-1:0] = STEP_W'($urandom);
            endcase
            write_reg(CFG_TIME_STEP, step_data);
            if ($urandom_range(1))
                write_reg(ph[0] ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
            // Phase two runs without gaps; phase three stalls the result side for a while
            if (ph == 2)
                calm = 1'b1;
            if (ph == 3)
                hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                offer_tick(quad(rand_drive(), rand_drive(), rand_drive(), rand_drive()),
                           1'b0, '0);
        end

        wait_states_out();
        calm = 1'b0;
        repeat (3 * TICK_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
